// ----- rtl/mfp_pkg.sv -----
// Shared types and constants for the message frame parser.
// No dependencies; all other files but mfp_stream_if import this package.
package mfp_pkg;

    localparam int HEADER_BYTES = 24;
    localparam int HDR_CNT_W    = $clog2(HEADER_BYTES);
    localparam logic [HDR_CNT_W-1:0] HDR_LAST_IDX = HDR_CNT_W'(HEADER_BYTES - 1);

    // result kinds
    localparam logic [1:0] KIND_HEADER = 2'd0;
    localparam logic [1:0] KIND_BYTE   = 2'd1;
    localparam logic [1:0] KIND_ERROR  = 2'd2;

    // result status codes
    localparam logic [2:0] ST_OK            = 3'd0;
    localparam logic [2:0] ST_SHORT_HEADER  = 3'd1;
    localparam logic [2:0] ST_BAD_MAGIC     = 3'd2;
    localparam logic [2:0] ST_BAD_VERSION   = 3'd3;
    localparam logic [2:0] ST_BAD_TYPE      = 3'd4;
    localparam logic [2:0] ST_TOO_LONG      = 3'd5;
    localparam logic [2:0] ST_SHORT_PAYLOAD = 3'd6;

    // configuration register indexes
    localparam logic [2:0] CFG_MAGIC   = 3'd0;
    localparam logic [2:0] CFG_VERSION = 3'd1;
    localparam logic [2:0] CFG_TYPE_LO = 3'd2;
    localparam logic [2:0] CFG_TYPE_HI = 3'd3;
    localparam logic [2:0] CFG_LIMIT   = 3'd4;

    typedef enum logic [2:0] {
        PH_HEADER  = 3'b001,
        PH_PAYLOAD = 3'b010,
        PH_DISCARD = 3'b100
    } t_phase;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       buffer_end;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  out_byte;
        logic [15:0] msg_type;
        logic [31:0] seq_number;
        logic [31:0] tick_value;
        logic [31:0] ack_value;
        logic [31:0] payload_len;
        logic [2:0]  status;
        logic        last;
    } t_out_item;

    // one queued action: a result, optionally followed by a short payload error
    typedef struct packed {
        t_out_item item;
        logic      short_err;
    } t_entry;

    typedef struct packed {
        logic   valid;
        t_entry entry;
    } t_qport;

endpackage

// ----- rtl/mfp_stream_if.sv -----
// Valid/ready stream channel carrying one payload struct per beat.
// Payload type is a parameter; types come from mfp_pkg.
interface mfp_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/mfp_front.sv -----
// Front end: accepts bytes, collects and checks the header, tracks payload.
// Pushes one action per result-producing beat into the queue. Uses mfp_pkg.
module mfp_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    mfp_stream_if.sink            i_in,
    input  logic                  i_cfg_we,
    input  logic [2:0]            i_cfg_idx,
    input  logic [31:0]           i_cfg_wdata,
    input  logic                  i_full,
    output mfp_pkg::t_qport       o_push
);
    import mfp_pkg::*;

    logic [31:0] r_magic;
    logic [15:0] r_version;
    logic [15:0] r_type_lo;
    logic [15:0] r_type_hi;
    logic [31:0] r_limit;

    t_phase                r_phase, n_phase;
    logic [HDR_CNT_W-1:0]  r_count, n_count;
    logic [31:0]           r_left, n_left;
    logic [7:0]            r_hdr [HEADER_BYTES-1];

    logic        w_accept;
    logic        w_hdr_wr;
    logic [31:0] w_left_dec;
    logic [31:0] w_magic, w_len, w_seq, w_tick, w_ack;
    logic [15:0] w_ver, w_type;
    logic [2:0]  w_status;
    t_in_item    w_in;

    assign w_in       = i_in.data;
    assign i_in.ready = !i_full;
    assign w_accept   = i_in.valid && !i_full;
    assign w_left_dec = r_left - 32'd1;

    assign w_magic = {r_hdr[3], r_hdr[2], r_hdr[1], r_hdr[0]};
    assign w_ver   = {r_hdr[5], r_hdr[4]};
    assign w_type  = {r_hdr[7], r_hdr[6]};
    assign w_len   = {r_hdr[11], r_hdr[10], r_hdr[9], r_hdr[8]};
    assign w_seq   = {r_hdr[15], r_hdr[14], r_hdr[13], r_hdr[12]};
    assign w_tick  = {r_hdr[19], r_hdr[18], r_hdr[17], r_hdr[16]};
    // final header byte is still on the input
    assign w_ack   = {w_in.in_byte, r_hdr[22], r_hdr[21], r_hdr[20]};

    always_comb begin
        if (w_magic != r_magic) begin
            w_status = ST_BAD_MAGIC;
        end else if (w_ver != r_version) begin
            w_status = ST_BAD_VERSION;
        end else if (w_type < r_type_lo || w_type > r_type_hi) begin
            w_status = ST_BAD_TYPE;
        end else if (w_len > r_limit) begin
            w_status = ST_TOO_LONG;
        end else begin
            w_status = ST_OK;
        end
    end

    always_comb begin
        n_phase  = r_phase;
        n_count  = r_count;
        n_left   = r_left;
        w_hdr_wr = 1'b0;
        o_push   = '0;
        if (w_accept) begin
            case (r_phase)
                PH_DISCARD: begin
                    if (w_in.buffer_end) begin
                        n_phase = PH_HEADER;
                    end
                end
                PH_PAYLOAD: begin
                    n_left                         = w_left_dec;
                    o_push.valid                   = 1'b1;
                    o_push.entry.item.kind         = KIND_BYTE;
                    o_push.entry.item.out_byte     = w_in.in_byte;
                    if (w_left_dec == 32'd0) begin
                        o_push.entry.item.last = 1'b1;
                        n_phase                = PH_HEADER;
                    end else if (w_in.buffer_end) begin
                        o_push.entry.short_err = 1'b1;
                        n_phase                = PH_HEADER;
                    end
                end
                default: begin
                    n_phase = PH_HEADER;
                    if (r_count != HDR_LAST_IDX) begin
                        w_hdr_wr = 1'b1;
                        if (w_in.buffer_end) begin
                            n_count                  = '0;
                            o_push.valid             = 1'b1;
                            o_push.entry.item.kind   = KIND_ERROR;
                            o_push.entry.item.status = ST_SHORT_HEADER;
                            o_push.entry.item.last   = 1'b1;
                        end else begin
                            n_count = r_count + 1'b1;
                        end
                    end else begin
                        n_count      = '0;
                        o_push.valid = 1'b1;
                        if (w_status != ST_OK) begin
                            o_push.entry.item.kind   = KIND_ERROR;
                            o_push.entry.item.status = w_status;
                            o_push.entry.item.last   = 1'b1;
                            n_phase = w_in.buffer_end ? PH_HEADER : PH_DISCARD;
                        end else begin
                            o_push.entry.item.kind        = KIND_HEADER;
                            o_push.entry.item.msg_type    = w_type;
                            o_push.entry.item.seq_number  = w_seq;
                            o_push.entry.item.tick_value  = w_tick;
                            o_push.entry.item.ack_value   = w_ack;
                            o_push.entry.item.payload_len = w_len;
                            if (w_len == 32'd0) begin
                                o_push.entry.item.last = 1'b1;
                            end else if (w_in.buffer_end) begin
                                o_push.entry.short_err = 1'b1;
                            end else begin
                                n_phase = PH_PAYLOAD;
                                n_left  = w_len;
                            end
                        end
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_HEADER;
            r_count   <= '0;
            r_left    <= '0;
            r_magic   <= '0;
            r_version <= '0;
            r_type_lo <= '0;
            r_type_hi <= '0;
            r_limit   <= '0;
        end else begin
            r_phase <= n_phase;
            r_count <= n_count;
            r_left  <= n_left;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_MAGIC:   r_magic   <= i_cfg_wdata;
                    CFG_VERSION: r_version <= i_cfg_wdata[15:0];
                    CFG_TYPE_LO: r_type_lo <= i_cfg_wdata[15:0];
                    CFG_TYPE_HI: r_type_hi <= i_cfg_wdata[15:0];
                    CFG_LIMIT:   r_limit   <= i_cfg_wdata;
                    default: ;
                endcase
            end
        end
    end

    // header bytes need no reset: each is written before the check reads it
    always_ff @(posedge i_clk) begin
        if (w_hdr_wr) begin
            r_hdr[r_count] <= w_in.in_byte;
        end
    end

endmodule

// ----- rtl/mfp_queue.sv -----
// Small action queue between the front end and the result stage.
// Register array with read and write pointers. Uses mfp_pkg.
module mfp_queue #(
    parameter int DEPTH = 4
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  mfp_pkg::t_qport i_push,
    input  logic            i_pop,
    output logic            o_full,
    output mfp_pkg::t_qport o_head
);
    import mfp_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_entry          r_mem [DEPTH];
    logic [PW-1:0]   r_wr_ptr, r_rd_ptr;
    logic [CW-1:0]   r_count;
    logic            w_push, w_pop;

    assign o_full       = (r_count == CW'(DEPTH));
    assign w_push       = i_push.valid && !o_full;
    assign w_pop        = i_pop && (r_count != '0);
    assign o_head.valid = (r_count != '0);
    assign o_head.entry = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_push.entry;
        end
    end

endmodule

// ----- rtl/mfp_back.sv -----
// Result stage: turns queued actions into output beats through a register.
// Adds the trailing short payload error when an action asks for it. Uses mfp_pkg.
module mfp_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  mfp_pkg::t_qport i_head,
    output logic            o_pop,
    mfp_stream_if.source    o_out
);
    import mfp_pkg::*;

    t_out_item r_out;
    logic      r_out_valid;
    logic      r_pend;
    logic      w_load;
    t_out_item w_err;

    always_comb begin
        w_err        = '0;
        w_err.kind   = KIND_ERROR;
        w_err.status = ST_SHORT_PAYLOAD;
        w_err.last   = 1'b1;
    end

    assign w_load      = !r_out_valid || o_out.ready;
    assign o_pop       = w_load && !r_pend && i_head.valid;
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_pend      <= 1'b0;
        end else if (w_load) begin
            if (r_pend) begin
                r_out_valid <= 1'b1;
                r_pend      <= 1'b0;
            end else begin
                r_out_valid <= i_head.valid;
                r_pend      <= i_head.valid && i_head.entry.short_err;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out <= r_pend ? w_err : i_head.entry.item;
        end
    end

endmodule

// ----- rtl/message_frame_parser_core.sv -----
// Top level of the length-prefixed frame parser: front end, queue, result stage.
// Depends on mfp_pkg, mfp_stream_if, mfp_front, mfp_queue and mfp_back.
//
//   port          dir   kind          beat content
//   i_in          in    valid/ready   in_byte, buffer_end
//   o_out         out   valid/ready   kind, out_byte, header fields, status, last
//   i_cfg_*       in    write only    5 registers, index 0..4, 32-bit data
//
// One input byte is taken per cycle while the queue has room.
// A byte gives zero, one or two result beats; the output register drains one
// beat per cycle while o_out is ready.
// The queue (QUEUE_DEPTH actions) absorbs output stalls; input stalls only
// when it is full. Results pass through the queue, then the output register.
// Reset is synchronous, active low, and clears phase, counters and config registers.
module message_frame_parser_core #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    mfp_stream_if.sink   i_in,
    mfp_stream_if.source o_out,
    input  logic         i_cfg_we,
    input  logic [2:0]   i_cfg_idx,
    input  logic [31:0]  i_cfg_wdata
);
    import mfp_pkg::*;

    t_qport w_push;
    t_qport w_head;
    logic   w_full;
    logic   w_pop;

    mfp_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (i_in),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_wdata(i_cfg_wdata),
        .i_full     (w_full),
        .o_push     (w_push)
    );

    mfp_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (w_push),
        .i_pop  (w_pop),
        .o_full (w_full),
        .o_head (w_head)
    );

    mfp_back u_back (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_head (w_head),
        .o_pop  (w_pop),
        .o_out  (o_out)
    );

endmodule

// ----- rtl/mfp_checker.sv -----
// Port-level checks on the parser's result channel, and the bind to the top.
// Depends on mfp_pkg and message_frame_parser_core.
module mfp_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_valid,
    input logic               i_ready,
    input mfp_pkg::t_out_item i_item
);
    import mfp_pkg::*;

    // a stalled beat holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid && $stable(i_item))
        else $error("result beat changed while stalled");

    // errors always close the frame with a nonzero status
    a_err_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_item.kind == KIND_ERROR |-> i_item.last && i_item.status != ST_OK)
        else $error("error beat without last or status");

    a_ok_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_item.kind != KIND_ERROR |-> i_item.status == ST_OK)
        else $error("status set on a non-error beat");

    // a header closes the frame exactly when the payload is empty
    a_hdr_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_item.kind == KIND_HEADER |-> i_item.last == (i_item.payload_len == 32'd0))
        else $error("header last flag disagrees with payload length");

endmodule

bind message_frame_parser_core mfp_checker u_mfp_checker (
    .i_clk  (i_clk),
    .i_rst_n(i_rst_n),
    .i_valid(o_out.valid),
    .i_ready(o_out.ready),
    .i_item (o_out.data)
);

// ----- tb/message_frame_parser_checker.sv -----
`timescale 1ns / 1ps
// Passive checker for message_frame_parser_core: watches the byte, result and register ports.
// Keeps its own frame parser model and a queue of expected result beats.
// Depends on mfp_pkg and mfp_stream_if.
module message_frame_parser_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    mfp_stream_if       i_bytes,
    mfp_stream_if       i_results,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_wdata,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_result_count
);
    import mfp_pkg::*;

    logic [31:0] reg_magic;
    logic [15:0] reg_version;
    logic [15:0] reg_type_lo;
    logic [15:0] reg_type_hi;
    logic [31:0] reg_limit;

    t_phase      parse_phase;
    logic [4:0]  hdr_count;
    logic [7:0]  hdr_bytes [HEADER_BYTES];
    logic [31:0] bytes_left;

    t_out_item   expected_results [$];
    int          fail_total;
    int          results_seen;

    function automatic string fmt_result(t_out_item r);
        return $sformatf({"kind=%0d byte=%02h type=%04h seq=%08h tick=%08h ack=%08h",
                          " len=%08h status=%0d last=%0b"},
                         r.kind, r.out_byte, r.msg_type, r.seq_number, r.tick_value,
                         r.ack_value, r.payload_len, r.status, r.last);
    endfunction

    task automatic note_failure(string msg);
        fail_total++;
        if (fail_total <= 10) begin
            $display("%s", msg);
        end
    endtask

    task automatic push_error(logic [2:0] st);
        t_out_item r;
        r        = '0;
        r.kind   = KIND_ERROR;
        r.status = st;
        r.last   = 1'b1;
        expected_results = {expected_results, r};
    endtask

    task automatic parse_byte(t_in_item beat);
        t_out_item   r;
        logic [31:0] mg;
        logic [15:0] ver;
        logic [15:0] typ;
        logic [31:0] len;
        logic [2:0]  st;
        r = '0;
        case (parse_phase)
            PH_DISCARD: begin
                if (beat.buffer_end) begin
                    parse_phase = PH_HEADER;
                end
            end
            PH_PAYLOAD: begin
                bytes_left = bytes_left - 32'd1;
                r.kind     = KIND_BYTE;
                r.out_byte = beat.in_byte;
                r.last     = (bytes_left == 32'd0);
                expected_results = {expected_results, r};
                if (bytes_left == 32'd0) begin
                    parse_phase = PH_HEADER;
                end else if (beat.buffer_end) begin
                    push_error(ST_SHORT_PAYLOAD);
                    parse_phase = PH_HEADER;
                    bytes_left  = '0;
                end
            end
            default: begin
                parse_phase          = PH_HEADER;
                hdr_bytes[hdr_count] = beat.in_byte;
                hdr_count            = hdr_count + 5'd1;
                if (hdr_count < HEADER_BYTES) begin
                    if (beat.buffer_end) begin
                        hdr_count = '0;
                        push_error(ST_SHORT_HEADER);
                    end
                end else begin
                    hdr_count = '0;
                    mg  = {hdr_bytes[3], hdr_bytes[2], hdr_bytes[1], hdr_bytes[0]};
                    ver = {hdr_bytes[5], hdr_bytes[4]};
                    typ = {hdr_bytes[7], hdr_bytes[6]};
                    len = {hdr_bytes[11], hdr_bytes[10], hdr_bytes[9], hdr_bytes[8]};
                    // checks run in fixed priority order
                    st = ST_OK;
                    if (mg != reg_magic) begin
                        st = ST_BAD_MAGIC;
                    end else if (ver != reg_version) begin
                        st = ST_BAD_VERSION;
                    end else if (typ < reg_type_lo || typ > reg_type_hi) begin
                        st = ST_BAD_TYPE;
                    end else if (len > reg_limit) begin
                        st = ST_TOO_LONG;
                    end
                    if (st != ST_OK) begin
                        push_error(st);
                        parse_phase = beat.buffer_end ? PH_HEADER : PH_DISCARD;
                    end else begin
                        r.kind        = KIND_HEADER;
                        r.msg_type    = typ;
                        r.payload_len = len;
                        r.seq_number  = {hdr_bytes[15], hdr_bytes[14],
                                         hdr_bytes[13], hdr_bytes[12]};
                        r.tick_value  = {hdr_bytes[19], hdr_bytes[18],
                                         hdr_bytes[17], hdr_bytes[16]};
                        r.ack_value   = {hdr_bytes[23], hdr_bytes[22],
                                         hdr_bytes[21], hdr_bytes[20]};
                        r.last        = (len == 32'd0);
                        expected_results = {expected_results, r};
                        if (len != 32'd0) begin
                            if (beat.buffer_end) begin
                                push_error(ST_SHORT_PAYLOAD);
                            end else begin
                                parse_phase = PH_PAYLOAD;
                                bytes_left  = len;
                            end
                        end
                    end
                end
            end
        endcase
    endtask

    initial begin
        fail_total   = 0;
        results_seen = 0;
    end

    always @(posedge i_clk) begin : watch
        t_out_item got;
        t_out_item want;
        if (!i_rst_n) begin
            reg_magic   = '0;
            reg_version = '0;
            reg_type_lo = '0;
            reg_type_hi = '0;
            reg_limit   = '0;
            parse_phase = PH_HEADER;
            hdr_count   = '0;
            bytes_left  = '0;
            foreach (hdr_bytes[i]) begin
                hdr_bytes[i] = '0;
            end
            expected_results.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_MAGIC:   reg_magic   = i_cfg_wdata;
                    CFG_VERSION: reg_version = i_cfg_wdata[15:0];
                    CFG_TYPE_LO: reg_type_lo = i_cfg_wdata[15:0];
                    CFG_TYPE_HI: reg_type_hi = i_cfg_wdata[15:0];
                    CFG_LIMIT:   reg_limit   = i_cfg_wdata;
                    default: ;
                endcase
            end
            if (i_results.valid && i_results.ready) begin
                got = i_results.data;
                results_seen++;
                if (expected_results.size() == 0) begin
                    note_failure($sformatf("unexpected result beat: %s", fmt_result(got)));
                end else begin
                    want = expected_results.pop_front();
                    if (got.kind !== want.kind || got.out_byte !== want.out_byte ||
                        got.msg_type !== want.msg_type || got.seq_number !== want.seq_number ||
                        got.tick_value !== want.tick_value || got.ack_value !== want.ack_value ||
                        got.payload_len !== want.payload_len || got.status !== want.status ||
                        got.last !== want.last) begin
                        note_failure($sformatf(
                            "result beat %0d mismatch\n  expected %s\n  actual   %s",
                            results_seen, fmt_result(want), fmt_result(got)));
                    end
                end
            end
            if (i_bytes.valid && i_bytes.ready) begin
                parse_byte(i_bytes.data);
            end
        end
        o_fail_count   <= fail_total;
        o_pending      <= expected_results.size();
        o_result_count <= results_seen;
    end

endmodule

// ----- tb/message_frame_parser_core_tb.sv -----
`timescale 1ns / 1ps
// Testbench top for message_frame_parser_core: clock, reset, framed byte stimulus,
// register settings and output back-pressure. Checking is in message_frame_parser_checker.
// Depends on mfp_pkg, mfp_stream_if, the checker and the block's RTL.
module message_frame_parser_core_tb;
    import mfp_pkg::*;

    logic        i_clk;
    logic        i_rst_n;
    logic        cfg_we;
    logic [2:0]  cfg_idx;
    logic [31:0] cfg_wdata;

    mfp_stream_if #(.T(t_in_item))  byte_ch ();
    mfp_stream_if #(.T(t_out_item)) result_ch ();

    int fail_count;
    int pending;
    int result_count;

    // current register values, used only to shape frames
    logic [31:0] cur_magic;
    logic [15:0] cur_version;
    logic [15:0] cur_type_lo;
    logic [15:0] cur_type_hi;
    logic [31:0] cur_limit;

    logic [7:0]  frame_buf [$];
    int          beats_sent;
    int          settings_used;
    bit          sender_steady;
    bit          hold_req;

    message_frame_parser_core uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (byte_ch),
        .o_out       (result_ch),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_wdata (cfg_wdata)
    );

    message_frame_parser_checker chk (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_bytes        (byte_ch),
        .i_results      (result_ch),
        .i_cfg_we       (cfg_we),
        .i_cfg_idx      (cfg_idx),
        .i_cfg_wdata    (cfg_wdata),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_result_count (result_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #200000;
        $display("run did not finish in time");
        $display("end of test: mismatches");
        $finish;
    end

    // result side: random stalls, one long hold-off, then a stretch with no stalls
    initial begin : drain
        int hold_left;
        int steady_left;
        bit hold_done;
        hold_left   = 0;
        steady_left = 0;
        hold_done   = 1'b0;
        result_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req && !hold_done) begin
                hold_done = 1'b1;
                hold_left = 300;
            end
            if (hold_left > 0) begin
                hold_left--;
                result_ch.ready <= 1'b0;
                if (hold_left == 0) begin
                    steady_left = 400;
                end
            end else if (steady_left > 0) begin
                steady_left--;
                result_ch.ready <= 1'b1;
            end else begin
                result_ch.ready <= ($urandom_range(99) >= 27);
            end
        end
    end

    task automatic send_beat(logic [7:0] b, logic end_flag);
        while (!sender_steady && $urandom_range(99) < 27) begin
            byte_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        byte_ch.valid <= 1'b1;
        byte_ch.data  <= t_in_item'{in_byte: b, buffer_end: end_flag};
        do @(posedge i_clk); while (!byte_ch.ready);
        beats_sent++;
    endtask

    // send the assembled buffer, marking its last byte as the buffer end
    task automatic send_buffer();
        foreach (frame_buf[i]) begin
            send_beat(frame_buf[i], i == frame_buf.size() - 1);
        end
        frame_buf.delete();
    endtask

    task automatic push_header(logic [31:0] magic, logic [15:0] ver, logic [15:0] typ,
                               logic [31:0] len, logic [31:0] seq, logic [31:0] tick,
                               logic [31:0] ack);
        logic [191:0] hdr;
        hdr = {ack, tick, seq, len, typ, ver, magic};
        for (int i = 0; i < HEADER_BYTES; i++) begin
            frame_buf = {frame_buf, hdr[8*i +: 8]};
        end
    endtask

    task automatic push_random(int n);
        repeat (n) frame_buf = {frame_buf, 8'($urandom)};
    endtask

    function automatic logic [15:0] pick_type();
        if (cur_type_lo <= cur_type_hi) begin
            return 16'($urandom_range(cur_type_hi, cur_type_lo));
        end
        return 16'($urandom);
    endfunction

    function automatic logic [15:0] pick_bad_type();
        if (cur_type_lo > cur_type_hi) begin
            return 16'($urandom);
        end
        if (cur_type_lo != 16'h0000 && (cur_type_hi == 16'hFFFF || $urandom_range(1) == 0)) begin
            return 16'($urandom_range(cur_type_lo - 1, 0));
        end
        if (cur_type_hi != 16'hFFFF) begin
            return 16'($urandom_range(16'hFFFF, cur_type_hi + 1));
        end
        return 16'($urandom);
    endfunction

    // keep full payloads short; hit the limit itself now and then when it is small
    function automatic logic [31:0] pick_len();
        if (cur_limit == 32'd0) begin
            return 32'd0;
        end
        if (cur_limit <= 32'd24 && $urandom_range(9) == 0) begin
            return cur_limit;
        end
        return $urandom_range(cur_limit < 32'd8 ? cur_limit : 32'd8, 0);
    endfunction

    task automatic good_frame();
        logic [31:0] len;
        len = pick_len();
        push_header(cur_magic, cur_version, pick_type(), len, $urandom, $urandom, $urandom);
        push_random(len);
    endtask

    task automatic random_buffer();
        int          pick;
        logic [31:0] len;
        pick = $urandom_range(99);
        if (pick < 55) begin
            repeat ($urandom_range(3, 1)) good_frame();
        end else if (pick < 63) begin
            push_header(cur_magic ^ (32'h1 << $urandom_range(31, 0)), cur_version, pick_type(),
                        pick_len(), $urandom, $urandom, $urandom);
            push_random($urandom_range(4, 0));
        end else if (pick < 69) begin
            push_header(cur_magic, cur_version ^ (16'h1 << $urandom_range(15, 0)), pick_type(),
                        pick_len(), $urandom, $urandom, $urandom);
            push_random($urandom_range(4, 0));
        end else if (pick < 75) begin
            push_header(cur_magic, cur_version, pick_bad_type(), pick_len(),
                        $urandom, $urandom, $urandom);
            push_random($urandom_range(4, 0));
        end else if (pick < 81) begin
            if (cur_limit == 32'hFFFF_FFFF) begin
                len = 32'hFFFF_FFFF;
            end else begin
                len = cur_limit + 32'd1;
                if ($urandom_range(3) == 0) begin
                    len = len + $urandom_range(~cur_limit - 32'd1, 0);
                end
            end
            push_header(cur_magic, cur_version, pick_type(), len, $urandom, $urandom, $urandom);
            push_random($urandom_range(4, 0));
        end else if (pick < 87) begin
            push_random($urandom_range(HEADER_BYTES - 1, 1));
        end else if (pick < 94) begin
            if (cur_limit == 32'd0) begin
                good_frame();
            end else begin
                if ($urandom_range(1) == 0) begin
                    len = $urandom_range(cur_limit, 1);
                end else begin
                    len = $urandom_range(cur_limit < 32'd8 ? cur_limit : 32'd8, 1);
                end
                push_header(cur_magic, cur_version, pick_type(), len, $urandom, $urandom, $urandom);
                push_random($urandom_range(len - 32'd1 < 32'd8 ? len - 32'd1 : 32'd8, 0));
            end
        end else begin
            push_random($urandom_range(40, 1));
        end
        send_buffer();
    endtask

    task automatic write_reg(logic [2:0] idx, logic [31:0] data);
        cfg_we    <= 1'b1;
        cfg_idx   <= idx;
        cfg_wdata <= data;
        @(posedge i_clk);
    endtask

    task automatic apply_setting(logic [31:0] magic, logic [15:0] ver, logic [15:0] type_lo,
                                 logic [15:0] type_hi, logic [31:0] limit);
        cur_magic   = magic;
        cur_version = ver;
        cur_type_lo = type_lo;
        cur_type_hi = type_hi;
        cur_limit   = limit;
        write_reg(CFG_MAGIC, magic);
        write_reg(CFG_VERSION, {16'($urandom), ver});
        write_reg(CFG_TYPE_LO, {16'($urandom), type_lo});
        write_reg(CFG_TYPE_HI, {16'($urandom), type_hi});
        write_reg(CFG_LIMIT, limit);
        // an index past the last register must leave everything alone
        write_reg(CFG_LIMIT + 3'($urandom_range(3, 1)), $urandom);
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    // drain every expected result, then allow for bytes still in flight that give none
    task automatic settle();
        int guard;
        guard = 0;
        byte_ch.valid <= 1'b0;
        repeat (2) @(posedge i_clk);
        while (pending != 0 && guard < 20000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (10) @(posedge i_clk);
    endtask

    initial begin : stimulus
        int phase_start;
        i_rst_n       <= 1'b0;
        cfg_we        <= 1'b0;
        cfg_idx       <= '0;
        cfg_wdata     <= '0;
        byte_ch.valid <= 1'b0;
        byte_ch.data  <= '0;
        cur_magic     = '0;
        cur_version   = '0;
        cur_type_lo   = '0;
        cur_type_hi   = '0;
        cur_limit     = '0;
        beats_sent    = 0;
        settings_used = 0;
        sender_steady = 1'b0;
        hold_req      = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset values: an all-zero header is a good empty frame, type 1 is out of range
        push_header('0, '0, '0, '0, '0, '0, '0);
        send_buffer();
        push_header('0, '0, 16'h0001, '0, '0, '0, '0);
        send_buffer();
        settle();

        apply_setting(32'hA5C3_0F81, 16'h0102, 16'h0010, 16'h0020, 32'd16);
        // lowest type, payload at the byte extremes
        push_header(cur_magic, cur_version, 16'h0010, 32'd3, 32'h0000_0000, 32'hFFFF_FFFF,
                    32'h1234_5678);
        frame_buf = {frame_buf, 8'h00};
        frame_buf = {frame_buf, 8'hFF};
        frame_buf = {frame_buf, 8'h5A};
        send_buffer();
        // highest type, payload exactly at the limit
        push_header(cur_magic, cur_version, 16'h0020, 32'd16, 32'hFFFF_FFFF, 32'h0000_0000,
                    32'hFFFF_FFFF);
        push_random(16);
        send_buffer();
        // bad magic, trailing bytes dropped
        push_header(cur_magic ^ 32'h8000_0000, cur_version, 16'h0018, 32'd0, $urandom,
                    $urandom, $urandom);
        push_random(3);
        send_buffer();
        // bad version, buffer ends on the last header byte
        push_header(cur_magic, cur_version ^ 16'h0001, 16'h0018, 32'd0, $urandom, $urandom,
                    $urandom);
        send_buffer();
        // types just outside the range
        push_header(cur_magic, cur_version, 16'h000F, 32'd1, $urandom, $urandom, $urandom);
        push_random(2);
        send_buffer();
        push_header(cur_magic, cur_version, 16'h0021, 32'd1, $urandom, $urandom, $urandom);
        send_buffer();
        // length one past the limit
        push_header(cur_magic, cur_version, 16'h0018, 32'd17, $urandom, $urandom, $urandom);
        push_random(1);
        send_buffer();
        // short headers
        push_random(10);
        send_buffer();
        push_random(1);
        send_buffer();
        // buffer ends on the header of a frame with payload
        push_header(cur_magic, cur_version, 16'h0011, 32'd5, $urandom, $urandom, $urandom);
        send_buffer();
        // buffer ends inside the payload
        push_header(cur_magic, cur_version, 16'h0012, 32'd4, $urandom, $urandom, $urandom);
        push_random(2);
        send_buffer();
        // empty frame then a one-byte frame in the same buffer
        push_header(cur_magic, cur_version, 16'h0013, 32'd0, $urandom, $urandom, $urandom);
        push_header(cur_magic, cur_version, 16'h0014, 32'd1, $urandom, $urandom, $urandom);
        push_random(1);
        send_buffer();
        settle();

        for (int s = 0; s < 5; s++) begin
            case (s)
                0: apply_setting(32'hFFFF_FFFF, 16'hFFFF, 16'h0000, 16'hFFFF, 32'hFFFF_FFFF);
                1: apply_setting(32'h0000_0000, 16'h0000, 16'hFFFF, 16'hFFFF, 32'd0);
                2: begin
                    apply_setting($urandom, 16'($urandom), 16'h4000, 16'h40FF,
                                  $urandom_range(12, 1));
                    hold_req = 1'b1;
                end
                // empty type range: every header fails the type check
                3: apply_setting($urandom, 16'($urandom), 16'h9000, 16'h8FFF, 32'd6);
                default: begin
                    apply_setting($urandom, 16'($urandom), 16'($urandom_range(16'h00FF, 0)),
                                  16'($urandom_range(16'hFFFF, 16'h0100)), $urandom_range(30, 0));
                    sender_steady = 1'b1;
                end
            endcase
            phase_start = beats_sent;
            while (beats_sent - phase_start < 130) begin
                random_buffer();
            end
            settle();
        end

        $display("covered %0d input beats and %0d result beats over %0d register settings,",
                 beats_sent, result_count, settings_used + 1);
        $display("including a long output hold-off and stall-free stretches on both sides");
        if (fail_count == 0 && pending == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/mfp_pkg.sv
rtl/mfp_stream_if.sv
rtl/mfp_front.sv
rtl/mfp_queue.sv
rtl/mfp_back.sv
rtl/message_frame_parser_core.sv
rtl/mfp_checker.sv
tb/message_frame_parser_checker.sv
tb/message_frame_parser_core_tb.sv
